[hw/rtl/rdp_pkg.sv]
`timescale 1ns / 1ps
package rdp_pkg;

  localparam int unsigned CoordW        = 16;
  localparam int unsigned ThrW          = 16;
  localparam int unsigned Thr2W         = 2 * ThrW;
  localparam int unsigned DiffW         = CoordW + 1;
  localparam int unsigned ProdW         = 2 * DiffW;
  localparam int unsigned CrossW        = ProdW + 1;
  localparam int unsigned MulW          = ProdW;
  localparam int unsigned MulPW         = 2 * MulW;
  localparam int unsigned DefMaxPoints  = 64;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLR,
    OP_LOAD,
    OP_INIT,
    OP_POP,
    OP_SPAN,
    OP_ORG,
    OP_END,
    OP_LEN_A,
    OP_LEN_B,
    OP_TL_GO,
    OP_TL_SAVE,
    OP_PT_RD,
    OP_PT_DIFF,
    OP_CR_A,
    OP_CR_B,
    OP_DS_A,
    OP_DS_B,
    OP_SQ_GO,
    OP_CMP,
    OP_SPLIT_A,
    OP_SPLIT_B,
    OP_EM_CHK,
    OP_EM_NEXT,
    OP_DONE
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } rdp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic short_run;
    logic stack_empty;
    logic mul_busy;
    logic scan_last;
    logic emit_kept;
    logic emit_last;
  } rdp_stat_t;

endpackage

[hw/rtl/rdp_point_if.sv]
`timescale 1ns / 1ps
interface rdp_point_if
  import rdp_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [CoordW-1:0] point_x;
  logic signed [CoordW-1:0] point_y;
  logic                     last_point;

  modport source (output valid, point_x, point_y, last_point, input ready);
  modport sink (input valid, point_x, point_y, last_point, output ready);
endinterface

[hw/rtl/rdp_kept_if.sv]
`timescale 1ns / 1ps
interface rdp_kept_if
  import rdp_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [CoordW-1:0] kept_x;
  logic signed [CoordW-1:0] kept_y;
  logic                     is_last;
  logic                     overflowed;

  modport source (output valid, kept_x, kept_y, is_last, overflowed, input ready);
  modport sink (input valid, kept_x, kept_y, is_last, overflowed, output ready);
endinterface

[hw/rtl/rdp_polyline_simplify.sv]
`timescale 1ns / 1ps
// channel   dir  payload                                  handshake
// point_i   in   point_x, point_y, last_point             valid/ready
// kept_o    out  kept_x, kept_y, is_last, overflowed      valid/ready
// cfg       in   cfg_wdata_i (distance_threshold)         cfg_we_i
//
// points load one a cycle; the beat with last_point starts simplification
// each span and each interior point waits on the bit-serial 34x34
// multiplier; emit reads and checks each point, then outputs it if kept
// after reset the keep mask is cleared entry by entry before loading
// input ready is low from the last point until the last result beat is taken
module rdp_polyline_simplify
  import rdp_pkg::*;
#(
  parameter int unsigned MAX_POINTS = DefMaxPoints
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [ThrW-1:0] cfg_wdata_i,
  rdp_point_if.sink       point_i,
  rdp_kept_if.source      kept_o
);
  rdp_cmd_t  cmd;
  rdp_stat_t stat;

  rdp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (point_i.valid),
    .in_last_i   (point_i.last_point),
    .in_ready_o  (point_i.ready),
    .out_valid_o (kept_o.valid),
    .out_ready_i (kept_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  rdp_dp #(
    .MaxPoints (MAX_POINTS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_x_i      (point_i.point_x),
    .in_y_i      (point_i.point_y),
    .out_x_o     (kept_o.kept_x),
    .out_y_o     (kept_o.kept_y),
    .out_last_o  (kept_o.is_last),
    .out_ovf_o   (kept_o.overflowed)
  );
endmodule

[hw/rtl/rdp_mul.sv]
`timescale 1ns / 1ps
module rdp_mul
  import rdp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [MulW-1:0]  a_i,
  input  logic [MulW-1:0]  b_i,
  output logic             busy_o,
  output logic [MulPW-1:0] p_o
);
  localparam int unsigned CntW = $clog2(MulW + 1);

  logic [CntW-1:0] cnt_q;
  logic [MulW-1:0] a_q, hi_q, lo_q;
  logic [MulW:0]   sum;

  // shift-add, one multiplier bit a cycle
  assign sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a_q} : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CntW'(MulW);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q  <= a_i;
      hi_q <= '0;
      lo_q <= b_i;
    end else if (cnt_q != '0) begin
      hi_q <= sum[MulW:1];
      lo_q <= {sum[0], lo_q[MulW-1:1]};
    end
  end

  assign busy_o = (cnt_q != '0);
  assign p_o    = {hi_q, lo_q};
endmodule

[hw/rtl/rdp_dp.sv]
`timescale 1ns / 1ps
module rdp_dp
  import rdp_pkg::*;
#(
  parameter int unsigned MaxPoints = DefMaxPoints
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  rdp_cmd_t                 cmd_i,
  output rdp_stat_t                stat_o,
  input  logic                     cfg_we_i,
  input  logic [ThrW-1:0]          cfg_wdata_i,
  input  logic signed [CoordW-1:0] in_x_i,
  input  logic signed [CoordW-1:0] in_y_i,
  output logic signed [CoordW-1:0] out_x_o,
  output logic signed [CoordW-1:0] out_y_o,
  output logic                     out_last_o,
  output logic                     out_ovf_o
);
  localparam int unsigned IW = $clog2(MaxPoints);
  localparam int unsigned CW = $clog2(MaxPoints + 1);

  // memories
  logic [2*CoordW-1:0] pt_mem [MaxPoints];
  logic                keep_mem [MaxPoints];
  logic [2*IW-1:0]     stk_mem [MaxPoints];
  logic [2*CoordW-1:0] pt_rd_q;
  logic                keep_rd_q;
  logic [2*IW-1:0]     stk_rd_q;

  logic [CW-1:0] count_q, sp_q;
  logic          ovf_q;
  logic [ThrW-1:0]  thr_q;
  logic [Thr2W-1:0] thr2_q;
  logic [IW-1:0] s_q, e_q, i_q, best_i_q, j_q, clr_ptr_q;
  logic signed [CoordW-1:0] sx_q, sy_q;
  logic signed [DiffW-1:0]  ex_q, ey_q, px_q, py_q;
  logic signed [ProdW-1:0]  prod_q;
  logic signed [CrossW-1:0] cross_q;
  logic [ProdW-1:0]  len2_q, dist2_q, best_q;
  logic [MulPW-1:0]  tl_q;
  logic signed [CoordW-1:0] out_x_q, out_y_q;
  logic out_last_q, out_ovf_q;

  logic [IW-1:0] pt_raddr, last_idx, stk_lo, stk_hi;
  logic signed [CoordW-1:0] rd_x, rd_y;
  logic signed [DiffW-1:0]  dx, dy, sm_a, sm_b;
  logic signed [ProdW-1:0]  sm_p;
  logic [ProdW-1:0]  cross_abs, metric;
  logic              over, emit_kept;
  logic              mul_start, mul_busy;
  logic [MulW-1:0]   mul_a, mul_b;
  logic [MulPW-1:0]  mul_p;
  logic              split, push_lo, push_hi;

  assign rd_x     = pt_rd_q[CoordW-1:0];
  assign rd_y     = pt_rd_q[2*CoordW-1:CoordW];
  assign dx       = DiffW'(rd_x) - DiffW'(sx_q);
  assign dy       = DiffW'(rd_y) - DiffW'(sy_q);
  assign last_idx = IW'(count_q - 1'b1);
  assign stk_lo   = stk_rd_q[IW-1:0];
  assign stk_hi   = stk_rd_q[2*IW-1:IW];

  always_comb begin
    case (cmd_i.op)
      OP_SPAN:  pt_raddr = stk_lo;
      OP_ORG:   pt_raddr = e_q;
      OP_PT_RD: pt_raddr = i_q;
      default:  pt_raddr = j_q;
    endcase
  end

  // one shared 17x17 signed multiplier
  always_comb begin
    case (cmd_i.op)
      OP_LEN_A: begin sm_a = ex_q; sm_b = ex_q; end
      OP_LEN_B: begin sm_a = ey_q; sm_b = ey_q; end
      OP_CR_A:  begin sm_a = px_q; sm_b = ey_q; end
      OP_CR_B:  begin sm_a = py_q; sm_b = ex_q; end
      OP_DS_A:  begin sm_a = px_q; sm_b = px_q; end
      default:  begin sm_a = py_q; sm_b = py_q; end
    endcase
  end
  assign sm_p = sm_a * sm_b;

  assign cross_abs = cross_q[CrossW-1] ? ProdW'(-cross_q) : ProdW'(cross_q);
  assign metric    = (len2_q == '0) ? dist2_q : cross_abs;
  assign over      = (len2_q == '0) ? (dist2_q > ProdW'(thr2_q)) : (mul_p > tl_q);

  assign mul_start = (cmd_i.op == OP_TL_GO) || (cmd_i.op == OP_SQ_GO);
  assign mul_a     = (cmd_i.op == OP_TL_GO) ? MulW'(thr2_q) : cross_abs;
  assign mul_b     = (cmd_i.op == OP_TL_GO) ? len2_q : cross_abs;

  rdp_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .busy_o  (mul_busy),
    .p_o     (mul_p)
  );

  assign split   = (best_i_q != s_q);
  assign push_lo = split && (({1'b0, s_q} + 1'b1) < {1'b0, best_i_q});
  assign push_hi = split && (({1'b0, best_i_q} + 1'b1) != {1'b0, e_q});

  assign emit_kept = keep_rd_q || (j_q == '0) || (j_q == last_idx) || stat_o.short_run;

  // memory ports
  always_ff @(posedge clk_i) begin
    pt_rd_q   <= pt_mem[pt_raddr];
    keep_rd_q <= keep_mem[j_q];
    stk_rd_q  <= stk_mem[IW'(sp_q - 1'b1)];
    if (cmd_i.op == OP_LOAD && count_q < CW'(MaxPoints)) begin
      pt_mem[count_q[IW-1:0]] <= {in_y_i, in_x_i};
    end
    case (cmd_i.op)
      OP_CLR:     keep_mem[clr_ptr_q] <= 1'b0;
      OP_SPLIT_A: if (split) keep_mem[best_i_q] <= 1'b1;
      OP_EM_CHK:  keep_mem[j_q] <= 1'b0;
      default: ;
    endcase
    if (sp_q < CW'(MaxPoints)) begin
      case (cmd_i.op)
        OP_INIT:    stk_mem[sp_q[IW-1:0]] <= {last_idx, IW'(0)};
        OP_SPLIT_A: if (push_lo) stk_mem[sp_q[IW-1:0]] <= {best_i_q, s_q};
        OP_SPLIT_B: if (push_hi) stk_mem[sp_q[IW-1:0]] <= {e_q, best_i_q};
        default: ;
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      sp_q      <= '0;
      ovf_q     <= 1'b0;
      thr_q     <= '0;
      clr_ptr_q <= '0;
      j_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      case (cmd_i.op)
        OP_CLR:  clr_ptr_q <= clr_ptr_q + 1'b1;
        OP_LOAD: begin
          if (count_q < CW'(MaxPoints)) count_q <= count_q + 1'b1;
          else ovf_q <= 1'b1;
        end
        OP_INIT: begin
          j_q  <= '0;
          sp_q <= CW'(1);
        end
        OP_POP:  sp_q <= sp_q - 1'b1;
        OP_SPLIT_A, OP_SPLIT_B: begin
          if (sp_q < CW'(MaxPoints) &&
              ((cmd_i.op == OP_SPLIT_A) ? push_lo : push_hi)) begin
            sp_q <= sp_q + 1'b1;
          end
        end
        OP_EM_CHK: if (!emit_kept) j_q <= j_q + 1'b1;
        OP_EM_NEXT: j_q <= j_q + 1'b1;
        OP_DONE: begin
          count_q <= '0;
          ovf_q   <= 1'b0;
          sp_q    <= '0;
          j_q     <= '0;
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_INIT: thr2_q <= Thr2W'(thr_q) * Thr2W'(thr_q);
      OP_SPAN: begin
        s_q      <= stk_lo;
        e_q      <= stk_hi;
        i_q      <= stk_lo + 1'b1;
        best_i_q <= stk_lo;
        best_q   <= '0;
      end
      OP_ORG: begin
        sx_q <= rd_x;
        sy_q <= rd_y;
      end
      OP_END: begin
        ex_q <= dx;
        ey_q <= dy;
      end
      OP_LEN_A, OP_CR_A, OP_DS_A: prod_q <= sm_p;
      OP_LEN_B: len2_q <= ProdW'(prod_q) + ProdW'(sm_p);
      OP_TL_SAVE: tl_q <= mul_p;
      OP_PT_DIFF: begin
        px_q <= dx;
        py_q <= dy;
      end
      OP_CR_B: cross_q <= CrossW'(prod_q) - CrossW'(sm_p);
      OP_DS_B: dist2_q <= ProdW'(prod_q) + ProdW'(sm_p);
      OP_CMP: begin
        if (over && metric > best_q) begin
          best_q   <= metric;
          best_i_q <= i_q;
        end
        i_q <= i_q + 1'b1;
      end
      OP_EM_CHK: begin
        out_x_q    <= rd_x;
        out_y_q    <= rd_y;
        out_last_q <= (j_q == last_idx);
        out_ovf_q  <= ovf_q;
      end
      default: ;
    endcase
  end

  assign stat_o.clr_last    = (clr_ptr_q == IW'(MaxPoints - 1));
  assign stat_o.short_run   = (count_q < CW'(3));
  assign stat_o.stack_empty = (sp_q == '0);
  assign stat_o.mul_busy    = mul_busy;
  assign stat_o.scan_last   = (({1'b0, i_q} + 1'b1) == {1'b0, e_q});
  assign stat_o.emit_kept   = emit_kept;
  assign stat_o.emit_last   = (j_q == last_idx);

  assign out_x_o    = out_x_q;
  assign out_y_o    = out_y_q;
  assign out_last_o = out_last_q;
  assign out_ovf_o  = out_ovf_q;
endmodule

[hw/rtl/rdp_ctrl.sv]
`timescale 1ns / 1ps
module rdp_ctrl
  import rdp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_last_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  rdp_stat_t stat_i,
  output rdp_cmd_t  cmd_o
);
  typedef enum logic [24:0] {
    ST_CLR     = 25'h0000001,
    ST_LOAD    = 25'h0000002,
    ST_INIT    = 25'h0000004,
    ST_POP     = 25'h0000008,
    ST_SPAN    = 25'h0000010,
    ST_ORG     = 25'h0000020,
    ST_END     = 25'h0000040,
    ST_LEN_A   = 25'h0000080,
    ST_LEN_B   = 25'h0000100,
    ST_TL_GO   = 25'h0000200,
    ST_TL_W    = 25'h0000400,
    ST_PT_RD   = 25'h0000800,
    ST_PT_DIFF = 25'h0001000,
    ST_CR_A    = 25'h0002000,
    ST_CR_B    = 25'h0004000,
    ST_DS_A    = 25'h0008000,
    ST_DS_B    = 25'h0010000,
    ST_SQ_GO   = 25'h0020000,
    ST_SQ_W    = 25'h0040000,
    ST_CMP     = 25'h0080000,
    ST_SPL_A   = 25'h0100000,
    ST_SPL_B   = 25'h0200000,
    ST_EM_RD   = 25'h0400000,
    ST_EM_CHK  = 25'h0800000,
    ST_EM_OUT  = 25'h1000000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    cmd_o.op  = OP_NONE;
    case (state_q)
      ST_CLR: begin
        cmd_o.op = OP_CLR;
        if (stat_i.clr_last) state_d = ST_LOAD;
      end
      ST_LOAD: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          if (in_last_i) state_d = ST_INIT;
        end
      end
      ST_INIT: begin
        cmd_o.op = OP_INIT;
        state_d  = stat_i.short_run ? ST_EM_RD : ST_POP;
      end
      ST_POP: begin
        if (stat_i.stack_empty) begin
          state_d = ST_EM_RD;
        end else begin
          cmd_o.op = OP_POP;
          state_d  = ST_SPAN;
        end
      end
      ST_SPAN:    begin cmd_o.op = OP_SPAN;    state_d = ST_ORG;     end
      ST_ORG:     begin cmd_o.op = OP_ORG;     state_d = ST_END;     end
      ST_END:     begin cmd_o.op = OP_END;     state_d = ST_LEN_A;   end
      ST_LEN_A:   begin cmd_o.op = OP_LEN_A;   state_d = ST_LEN_B;   end
      ST_LEN_B:   begin cmd_o.op = OP_LEN_B;   state_d = ST_TL_GO;   end
      ST_TL_GO:   begin cmd_o.op = OP_TL_GO;   state_d = ST_TL_W;    end
      ST_TL_W: begin
        if (!stat_i.mul_busy) begin
          cmd_o.op = OP_TL_SAVE;
          state_d  = ST_PT_RD;
        end
      end
      ST_PT_RD:   begin cmd_o.op = OP_PT_RD;   state_d = ST_PT_DIFF; end
      ST_PT_DIFF: begin cmd_o.op = OP_PT_DIFF; state_d = ST_CR_A;    end
      ST_CR_A:    begin cmd_o.op = OP_CR_A;    state_d = ST_CR_B;    end
      ST_CR_B:    begin cmd_o.op = OP_CR_B;    state_d = ST_DS_A;    end
      ST_DS_A:    begin cmd_o.op = OP_DS_A;    state_d = ST_DS_B;    end
      ST_DS_B:    begin cmd_o.op = OP_DS_B;    state_d = ST_SQ_GO;   end
      ST_SQ_GO:   begin cmd_o.op = OP_SQ_GO;   state_d = ST_SQ_W;    end
      ST_SQ_W: begin
        if (!stat_i.mul_busy) state_d = ST_CMP;
      end
      ST_CMP: begin
        cmd_o.op = OP_CMP;
        state_d  = stat_i.scan_last ? ST_SPL_A : ST_PT_RD;
      end
      ST_SPL_A:   begin cmd_o.op = OP_SPLIT_A; state_d = ST_SPL_B;   end
      ST_SPL_B:   begin cmd_o.op = OP_SPLIT_B; state_d = ST_POP;     end
      ST_EM_RD:   state_d = ST_EM_CHK;
      ST_EM_CHK: begin
        cmd_o.op = OP_EM_CHK;
        state_d  = stat_i.emit_kept ? ST_EM_OUT : ST_EM_RD;
      end
      ST_EM_OUT: begin
        if (out_ready_i) begin
          if (stat_i.emit_last) begin
            cmd_o.op = OP_DONE;
            state_d  = ST_LOAD;
          end else begin
            cmd_o.op = OP_EM_NEXT;
            state_d  = ST_EM_RD;
          end
        end
      end
      default: state_d = ST_CLR;
    endcase
  end

  assign in_ready_o  = (state_q == ST_LOAD);
  assign out_valid_o = (state_q == ST_EM_OUT);
endmodule
